// ===== rtl/core/hrs_pkg.sv =====
`default_nettype none

package hrs_pkg;

   // default widths
   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int PHASE_FRAC_BITS_DEF = 16;

   // phase keeps five integer bits above the fraction
   localparam int PHASE_INT_BITS = 5;

   // results per input frame and the counter that tracks them
   localparam int MAX_OUT = 17;
   localparam int CNT_W   = $clog2(MAX_OUT + 1);

   // pipeline stages from phase issue up to the lane sum
   localparam int NUM_STAGES = 6;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic STEREO_RESET = 1'b1;

   // register indexes, byte address is 4 * index
   typedef enum logic [0:0] {
      REG_PHASE_STEP  = 1'b0,
      REG_STEREO_MODE = 1'b1
   } csr_idx_type;

   // pipeline control shared by the weight unit and the lanes
   typedef struct packed {
      logic adv;   // all pipeline stages move one step
      logic load;  // new input frame enters the history
   } hrs_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/hrs_if.sv =====
`default_nettype none

// input frame channel
interface hrs_req_if
   import hrs_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] left_in;
   logic signed [SAMPLE_WIDTH-1:0] right_in;

   modport source (output valid, left_in, right_in, input ready);
   modport sink   (input valid, left_in, right_in, output ready);
endinterface

// result frame channel
interface hrs_rsp_if
   import hrs_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] left_out;
   logic signed [SAMPLE_WIDTH-1:0] right_out;
   logic                           last_of_run;

   modport source (output valid, left_out, right_out, last_of_run, input ready);
   modport sink   (input valid, left_out, right_out, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hrs_weights.sv =====
`default_nettype none

// cubic hermite basis weights from the phase, three register stages
module hrs_weights
   import hrs_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire hrs_ctl_type                       ctl,
   input  wire logic [PHASE_FRAC_BITS:0]          u,
   output logic signed [PHASE_FRAC_BITS+2:0]      w0,
   output logic signed [PHASE_FRAC_BITS+2:0]      w1,
   output logic signed [PHASE_FRAC_BITS+2:0]      w2,
   output logic signed [PHASE_FRAC_BITS+2:0]      w3
);

   localparam int F  = PHASE_FRAC_BITS;
   localparam int UW = F + 1;
   localparam int PW = 2 * UW;
   localparam int WW = F + 3;
   localparam logic [PW-1:0]        HALF  = PW'(1) << (F - 1);
   localparam logic signed [WW-1:0] ONE_S = WW'(1) <<< F;

   logic [PW-1:0] sq;
   logic [PW-1:0] cube;
   logic [UW-1:0] mu2_in;
   logic [UW-1:0] mu2_ff;
   logic [UW-1:0] u2_ff;
   logic [UW-1:0] mu3_in;
   logic [UW-1:0] mu3_ff;
   logic [UW-1:0] mu2b_ff;
   logic [UW-1:0] u3_ff;
   logic signed [WW-1:0] mu2s;
   logic signed [WW-1:0] mu3s;
   logic signed [WW-1:0] us;
   logic signed [WW-1:0] w0_in;
   logic signed [WW-1:0] w1_in;
   logic signed [WW-1:0] w2_in;
   logic signed [WW-1:0] w3_in;
   logic signed [WW-1:0] w0_ff;
   logic signed [WW-1:0] w1_ff;
   logic signed [WW-1:0] w2_ff;
   logic signed [WW-1:0] w3_ff;

   // square of the phase, rounded half up
   assign sq     = {{UW{1'b0}}, u} * {{UW{1'b0}}, u} + HALF;
   assign mu2_in = sq[F +: UW];

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         mu2_ff <= mu2_in;
         u2_ff  <= u;
      end
   end

   // cube of the phase, rounded half up
   assign cube   = {{UW{1'b0}}, mu2_ff} * {{UW{1'b0}}, u2_ff} + HALF;
   assign mu3_in = cube[F +: UW];

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         mu3_ff  <= mu3_in;
         mu2b_ff <= mu2_ff;
         u3_ff   <= u2_ff;
      end
   end

   // basis weights, tension and bias zero
   assign mu2s = signed'({2'b00, mu2b_ff});
   assign mu3s = signed'({2'b00, mu3_ff});
   assign us   = signed'({2'b00, u3_ff});

   assign w0_in = (mu3s <<< 1) - (mu2s + (mu2s <<< 1)) + ONE_S;
   assign w1_in = mu3s - (mu2s <<< 1) + us;
   assign w2_in = mu3s - mu2s;
   assign w3_in = (mu2s <<< 1) + mu2s - (mu3s <<< 1);

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         w0_ff <= w0_in;
         w1_ff <= w1_in;
         w2_ff <= w2_in;
         w3_ff <= w3_in;
      end
   end

   assign w0 = w0_ff;
   assign w1 = w1_ff;
   assign w2 = w2_ff;
   assign w3 = w3_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hrs_lane.sv =====
`default_nettype none

// one channel: sample history, weighted products, sum, round and saturate
module hrs_lane
   import hrs_pkg::*;
#(
   parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
   parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hrs_ctl_type                       ctl,
   input  wire logic signed [SAMPLE_WIDTH-1:0]    din,
   input  wire logic signed [PHASE_FRAC_BITS+2:0] w0,
   input  wire logic signed [PHASE_FRAC_BITS+2:0] w1,
   input  wire logic signed [PHASE_FRAC_BITS+2:0] w2,
   input  wire logic signed [PHASE_FRAC_BITS+2:0] w3,
   output logic signed [SAMPLE_WIDTH-1:0]         y
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int F    = PHASE_FRAC_BITS;
   localparam int WW   = F + 3;
   localparam int DW   = SW + 1;
   localparam int PW   = WW + DW;
   localparam int SUMW = PW + 2;
   localparam logic signed [SUMW-1:0] RND  = SUMW'(1) <<< F;
   localparam logic signed [SUMW-1:0] SMAX = (SUMW'(1) <<< (SW - 1)) - SUMW'(1);
   localparam logic signed [SUMW-1:0] SMIN = ~SMAX;

   // a oldest, b, c, d newest frame of the current item
   logic signed [SW-1:0] a_ff;
   logic signed [SW-1:0] b_ff;
   logic signed [SW-1:0] c_ff;
   logic signed [SW-1:0] d_ff;
   logic signed [DW-1:0] b2;
   logic signed [DW-1:0] c2;
   logic signed [DW-1:0] ca;
   logic signed [DW-1:0] db;
   logic signed [PW-1:0] p0_ff;
   logic signed [PW-1:0] p1_ff;
   logic signed [PW-1:0] p2_ff;
   logic signed [PW-1:0] p3_ff;
   logic signed [SUMW-1:0] s_in;
   logic signed [SUMW-1:0] s_ff;
   logic signed [SUMW-1:0] q;

   // history shift, once per input frame
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
         c_ff <= '0;
         d_ff <= '0;
      end else if (ctl.load) begin
         a_ff <= b_ff;
         b_ff <= c_ff;
         c_ff <= d_ff;
         d_ff <= din;
      end
   end

   // operands of the four products
   assign b2 = signed'({b_ff, 1'b0});
   assign c2 = signed'({c_ff, 1'b0});
   assign ca = DW'(c_ff) - DW'(a_ff);
   assign db = DW'(d_ff) - DW'(b_ff);

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         p0_ff <= PW'(w0) * PW'(b2);
         p1_ff <= PW'(w1) * PW'(ca);
         p2_ff <= PW'(w2) * PW'(db);
         p3_ff <= PW'(w3) * PW'(c2);
      end
   end

   // sum with the rounding offset
   assign s_in = SUMW'(p0_ff) + SUMW'(p1_ff) + SUMW'(p2_ff) + SUMW'(p3_ff) + RND;

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         s_ff <= s_in;
      end
   end

   // drop the fraction bits and floor divide by two, then saturate to the sample range
   assign q = s_ff >>> (F + 1);

   always_comb begin
      priority if (q > SMAX) begin
         y = SMAX[SW-1:0];
      end else if (q < SMIN) begin
         y = SMIN[SW-1:0];
      end else begin
         y = q[SW-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/hermite_audio_resampler_unit.sv =====
// the first result frame of an input reaches rsp through the phase generator, the weight
//   and lane pipeline and the output register; an input with n results yields one result per
//   cycle while rsp is not stalled; an input with no result leaves the block ready for the next input
// the six-stage weight and lane pipeline drains before the next input is taken
// reset (synchronous, active high) clears history and phase, sets phase_step to 1.0
//   and stereo_mode to stereo
`default_nettype none

module hermite_audio_resampler_unit
   import hrs_pkg::*;
#(
   parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
   parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   hrs_req_if.sink                    req,
   hrs_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int F   = PHASE_FRAC_BITS;
   localparam int PHW = F + PHASE_INT_BITS;
   localparam int UW  = F + 1;
   localparam int WW  = F + 3;
   localparam logic [PHW-1:0] ONE      = PHW'(1) << F;
   localparam logic [PHW-1:0] STEP_MIN = ONE >> 4;
   localparam logic [PHW-1:0] STEP_MAX = ONE << 4;

   logic              csr_wr;
   csr_idx_type       csr_idx;
   logic [PHW-1:0]    step_ff;
   logic              stereo_ff;
   logic [PHW-1:0]    step_eff;

   logic              adv;
   logic              accept;
   logic              issue;
   logic              last_issue;
   logic              active_ff;
   logic              active_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic [PHW-1:0]    ph_ff;
   logic [PHW-1:0]    ph_in;
   logic [PHW-1:0]    ph_sum;
   logic [PHW-1:0]    drop_src;
   logic [PHW-1:0]    ph_drop;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] lst_ff;
   logic [UW-1:0]         u_ff;
   hrs_ctl_type           ctl;

   logic signed [WW-1:0]  w0;
   logic signed [WW-1:0]  w1;
   logic signed [WW-1:0]  w2;
   logic signed [WW-1:0]  w3;
   logic signed [SW-1:0]  y_left;
   logic signed [SW-1:0]  y_right;

   logic                  rsp_valid_ff;
   logic signed [SW-1:0]  left_ff;
   logic signed [SW-1:0]  right_ff;
   logic                  last_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_idx_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= ONE;
         stereo_ff <= STEREO_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PHASE_STEP:  step_ff   <= csr_pwdata[PHW-1:0];
            REG_STEREO_MODE: stereo_ff <= csr_pwdata[0];
            default:         step_ff   <= step_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PHASE_STEP:  csr_prdata = CSR_DATA_W'(step_ff);
         REG_STEREO_MODE: csr_prdata = CSR_DATA_W'(stereo_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // step held inside one sixteenth and sixteen
   always_comb begin
      priority if (step_ff < STEP_MIN) begin
         step_eff = STEP_MIN;
      end else if (step_ff > STEP_MAX) begin
         step_eff = STEP_MAX;
      end else begin
         step_eff = step_ff;
      end
   end

   // handshake and pipeline advance
   assign adv       = !rsp_valid_ff || rsp.ready;
   assign req.ready = !active_ff && (vld_ff == '0);
   assign accept    = req.valid && req.ready;
   assign issue     = active_ff && adv;
   assign ctl.adv   = adv;
   assign ctl.load  = accept;

   // phase generator, one output phase per cycle while rsp is not stalled
   assign ph_sum     = ph_ff + step_eff;
   assign last_issue = (ph_sum > ONE) || (cnt_ff == CNT_W'(MAX_OUT - 1));
   assign drop_src   = accept ? ph_ff : ph_sum;
   assign ph_drop    = (drop_src > ONE) ? (drop_src - ONE) : '0;

   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      ph_in     = ph_ff;
      priority if (accept) begin
         cnt_in = '0;
         if (ph_ff <= ONE) begin
            active_in = 1'b1;
         end else begin
            ph_in = ph_drop;
         end
      end else if (issue) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_issue) begin
            active_in = 1'b0;
            ph_in     = ph_drop;
         end else begin
            ph_in = ph_sum;
         end
      end else begin
         ph_in = ph_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         ph_ff     <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         ph_ff     <= ph_in;
      end
   end

   // valid and last markers alongside the arithmetic stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lst_ff <= {lst_ff[NUM_STAGES-2:0], last_issue};
         u_ff   <= ph_ff[UW-1:0];
      end
   end

   hrs_weights #(
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_weights (
      .clock (clock),
      .ctl   (ctl),
      .u     (u_ff),
      .w0    (w0),
      .w1    (w1),
      .w2    (w2),
      .w3    (w3)
   );

   hrs_lane #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_lane_left (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .din   (req.left_in),
      .w0    (w0),
      .w1    (w1),
      .w2    (w2),
      .w3    (w3),
      .y     (y_left)
   );

   hrs_lane #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_lane_right (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .din   (req.right_in),
      .w0    (w0),
      .w1    (w1),
      .w2    (w2),
      .w3    (w3),
      .y     (y_right)
   );

   // merge stage and output register, right copies left in mono
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[NUM_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         left_ff  <= y_left;
         right_ff <= stereo_ff ? y_right : y_left;
         last_ff  <= lst_ff[NUM_STAGES-1];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.left_out    = left_ff;
   assign rsp.right_out   = right_ff;
   assign rsp.last_of_run = last_ff;

   // never more results per input than the guard allows
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_OUT))
      else $error("result count past limit");

   // final phase issue ends the run
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (issue && last_issue) |=> !active_ff)
      else $error("generator still active after last issue");

   // an input that arrives at phase up to one starts a fresh run
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (ph_ff <= ONE)) |=> (active_ff && (cnt_ff == '0)))
      else $error("run did not start");

   // between runs the phase stays within the largest step
   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (ph_ff <= STEP_MAX))
      else $error("idle phase out of range");

endmodule

`default_nettype wire
